[design/bes_pkg.sv]
package bes_pkg;

    // Field and register widths
    localparam int unsigned NOW_W      = 32;
    localparam int unsigned RND_W      = 16;
    localparam int unsigned DUR_W      = 16;
    localparam int unsigned INT_W      = 15;
    localparam int unsigned LEVEL_W    = 16;
    localparam int unsigned CODE_W     = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Serial divider step counts: 15 quotient bits for a ramp, 16 dividend bits for a modulo
    localparam int unsigned FRAC_STEPS = 15;
    localparam int unsigned MOD_STEPS  = 16;
    localparam int unsigned CNT_W      = 5;

    // Fully open level in Q1.15
    localparam logic [LEVEL_W-1:0] LEVEL_ONE = 16'h8000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSING  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSED   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OPENING  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd3;

    // Configuration reset values
    localparam logic [DUR_W-1:0] CLOSING_RST  = 16'd100;
    localparam logic [DUR_W-1:0] CLOSED_RST   = 16'd50;
    localparam logic [DUR_W-1:0] OPENING_RST  = 16'd150;
    localparam logic [INT_W-1:0] INTERVAL_RST = 15'd4000;

    // Result phase codes
    localparam logic [CODE_W-1:0] CODE_CLOSING = 2'd0;
    localparam logic [CODE_W-1:0] CODE_CLOSED  = 2'd1;
    localparam logic [CODE_W-1:0] CODE_OPENING = 2'd2;

    typedef enum logic [1:0] {
        DIV_MOD_FIRST,
        DIV_MOD_NEXT,
        DIV_FRAC_CLOSE,
        DIV_FRAC_OPEN
    } div_mode_t;

    typedef enum logic [1:0] {
        LVL_ZERO,
        LVL_ONE,
        LVL_QUOT
    } level_sel_t;

    typedef enum logic {
        BASE_ZERO,
        BASE_INTERVAL
    } base_sel_t;

    typedef struct packed {
        logic                take_in;
        logic                upd_start;
        logic                div_start;
        div_mode_t           div_mode;
        logic                upd_next;
        base_sel_t           base_sel;
        logic                load_out;
        level_sel_t          level_sel;
        logic [CODE_W-1:0]   code;
    } cmd_t;

    typedef struct packed {
        logic e_zero;
        logic e_ge_closing;
        logic e_ge_closed;
        logic e_ge_opening;
        logic blink_due;
        logic div_busy;
        logic out_full;
    } sts_t;

endpackage

[design/bes_datapath.sv]
module bes_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [bes_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  logic [bes_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic [bes_pkg::NOW_W+bes_pkg::RND_W-1:0] s_tdata,
    output logic [bes_pkg::LEVEL_W-1:0]          m_tdata,
    output logic [bes_pkg::CODE_W-1:0]           m_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  bes_pkg::cmd_t                        cmd,
    output bes_pkg::sts_t                        sts
);

    localparam int unsigned NW = bes_pkg::NOW_W;
    localparam int unsigned RW = bes_pkg::RND_W;
    localparam int unsigned DW = bes_pkg::DUR_W;
    localparam int unsigned IW = bes_pkg::INT_W;
    localparam int unsigned LW = bes_pkg::LEVEL_W;
    localparam int unsigned CW = bes_pkg::CNT_W;

    logic [DW-1:0]              closing_reg;
    logic [DW-1:0]              closed_reg;
    logic [DW-1:0]              opening_reg;
    logic [IW-1:0]              interval_reg;

    logic [NW-1:0]              now_reg;
    logic [RW-1:0]              rnd_reg;
    logic [NW-1:0]              start_reg;
    logic [NW-1:0]              next_reg;

    logic [DW-1:0]              rem_reg;
    logic [DW-1:0]              sh_reg;
    logic [DW-1:0]              dvs_reg;
    logic [CW-1:0]              cnt_reg;

    logic [LW-1:0]              level_reg;
    logic [bes_pkg::CODE_W-1:0] code_reg;
    logic                       out_valid_reg;

    logic [NW-1:0]              elapsed;
    logic [NW-1:0]              due_diff;
    logic [DW:0]                trial;
    logic                       qbit;
    logic [DW-1:0]              mod_res;
    logic [NW-1:0]              base_add;
    logic [LW-1:0]              level_next;

    // Elapsed time and phase-end tests, all under 32-bit wraparound
    assign elapsed  = now_reg - start_reg;
    assign due_diff = now_reg - next_reg;

    assign sts.e_zero       = (elapsed == '0);
    assign sts.e_ge_closing = (elapsed >= NW'(closing_reg));
    assign sts.e_ge_closed  = (elapsed >= NW'(closed_reg));
    assign sts.e_ge_opening = (elapsed >= NW'(opening_reg));
    assign sts.blink_due    = ~due_diff[NW-1];
    assign sts.div_busy     = (cnt_reg != '0);
    assign sts.out_full     = out_valid_reg;

    // One restoring division step: shift in the next dividend bit and try a subtract
    assign trial   = {rem_reg, sh_reg[DW-1]};
    assign qbit    = (trial >= {1'b0, dvs_reg});
    // A zero modulus gives a zero remainder
    assign mod_res = (dvs_reg == '0) ? '0 : rem_reg;
    assign base_add = (cmd.base_sel == bes_pkg::BASE_INTERVAL) ? NW'(interval_reg) : '0;

    // Level selection for the result beat
    always_comb
    begin
        case (cmd.level_sel)
            bes_pkg::LVL_ZERO: level_next = '0;
            bes_pkg::LVL_ONE:  level_next = bes_pkg::LEVEL_ONE;
            bes_pkg::LVL_QUOT: level_next = sh_reg;
            default:           level_next = '0;
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            closing_reg  <= bes_pkg::CLOSING_RST;
            closed_reg   <= bes_pkg::CLOSED_RST;
            opening_reg  <= bes_pkg::OPENING_RST;
            interval_reg <= bes_pkg::INTERVAL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                bes_pkg::CFG_CLOSING:  closing_reg  <= cfg_wdata[DW-1:0];
                bes_pkg::CFG_CLOSED:   closed_reg   <= cfg_wdata[DW-1:0];
                bes_pkg::CFG_OPENING:  opening_reg  <= cfg_wdata[DW-1:0];
                bes_pkg::CFG_INTERVAL: interval_reg <= cfg_wdata[IW-1:0];
            endcase
        end
    end

    // Timing state: phase start and next blink time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            next_reg  <= '0;
        end
        else
        begin
            if (cmd.upd_start)
            begin
                start_reg <= now_reg;
            end
            if (cmd.upd_next)
            begin
                next_reg <= now_reg + base_add + NW'(mod_res);
            end
        end
    end

    // Input capture; payload needs no reset
    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            now_reg <= s_tdata[NW-1:0];
            rnd_reg <= s_tdata[NW+RW-1:NW];
        end
    end

    // Serial divider step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            if (cmd.div_mode == bes_pkg::DIV_MOD_FIRST || cmd.div_mode == bes_pkg::DIV_MOD_NEXT)
            begin
                cnt_reg <= CW'(bes_pkg::MOD_STEPS);
            end
            else
            begin
                cnt_reg <= CW'(bes_pkg::FRAC_STEPS);
            end
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Serial divider operands: a ramp starts with the numerator as remainder,
    // a modulo shifts the random word in from the top
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            case (cmd.div_mode)
                bes_pkg::DIV_MOD_FIRST:
                begin
                    dvs_reg <= {interval_reg, 1'b0};
                    rem_reg <= '0;
                    sh_reg  <= rnd_reg;
                end
                bes_pkg::DIV_MOD_NEXT:
                begin
                    dvs_reg <= DW'(interval_reg);
                    rem_reg <= '0;
                    sh_reg  <= rnd_reg;
                end
                bes_pkg::DIV_FRAC_CLOSE:
                begin
                    dvs_reg <= closing_reg;
                    rem_reg <= closing_reg - elapsed[DW-1:0];
                    sh_reg  <= '0;
                end
                default:
                begin
                    dvs_reg <= opening_reg;
                    rem_reg <= elapsed[DW-1:0];
                    sh_reg  <= '0;
                end
            endcase
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= qbit ? DW'(trial - {1'b0, dvs_reg}) : trial[DW-1:0];
            sh_reg  <= {sh_reg[DW-2:0], qbit};
        end
    end

    // Output register: holds a beat until the master side takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            level_reg <= level_next;
            code_reg  <= cmd.code;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = level_reg;
    assign m_tuser  = code_reg;

    // The output level, ramp quotient included, never passes the fully open level
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (level_reg <= bes_pkg::LEVEL_ONE))
        else $error("openness above fully open");

    // The step counter never runs beyond the longest division
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(bes_pkg::MOD_STEPS))
        else $error("divider step counter out of range");

endmodule

[design/bes_controller.sv]
module bes_controller (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  bes_pkg::sts_t sts,
    output bes_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_EMIT
    } state_t;

    typedef enum logic [2:0] {
        PH_FIRST    = 3'd0,
        PH_INTERVAL = 3'd1,
        PH_CLOSING  = 3'd2,
        PH_CLOSED   = 3'd3,
        PH_OPENING  = 3'd4
    } phase_t;

    state_t                     state_reg, state_next;
    phase_t                     phase_reg, phase_next;
    bes_pkg::level_sel_t        lvl_reg, lvl_next;
    logic [bes_pkg::CODE_W-1:0] code_reg, code_next;
    bes_pkg::base_sel_t         base_reg, base_next;
    logic                       upd_after_reg, upd_after_next;
    logic                       emit_after_reg, emit_after_next;

    assign s_tready = (state_reg == S_IDLE);

    // Next state and command decode
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        lvl_next        = lvl_reg;
        code_next       = code_reg;
        base_next       = base_reg;
        upd_after_next  = upd_after_reg;
        emit_after_next = emit_after_reg;

        cmd           = '0;
        cmd.div_mode  = bes_pkg::DIV_MOD_FIRST;
        cmd.base_sel  = base_reg;
        cmd.level_sel = lvl_reg;
        cmd.code      = code_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.take_in = 1'b1;
                    state_next  = S_EVAL;
                end
            end

            S_EVAL:
            begin
                unique case (phase_reg)
                    PH_INTERVAL:
                    begin
                        if (sts.blink_due)
                        begin
                            cmd.upd_start = 1'b1;
                            phase_next    = PH_CLOSING;
                        end
                        state_next = S_IDLE;
                    end

                    PH_CLOSING:
                    begin
                        code_next = bes_pkg::CODE_CLOSING;
                        if (sts.e_ge_closing)
                        begin
                            lvl_next      = bes_pkg::LVL_ZERO;
                            cmd.upd_start = 1'b1;
                            phase_next    = PH_CLOSED;
                            state_next    = S_EMIT;
                        end
                        else if (sts.e_zero)
                        begin
                            // Start of the closing ramp: the eye is still fully open
                            lvl_next   = bes_pkg::LVL_ONE;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            lvl_next        = bes_pkg::LVL_QUOT;
                            cmd.div_start   = 1'b1;
                            cmd.div_mode    = bes_pkg::DIV_FRAC_CLOSE;
                            upd_after_next  = 1'b0;
                            emit_after_next = 1'b1;
                            state_next      = S_DIV;
                        end
                    end

                    PH_CLOSED:
                    begin
                        code_next = bes_pkg::CODE_CLOSED;
                        lvl_next  = bes_pkg::LVL_ZERO;
                        if (sts.e_ge_closed)
                        begin
                            cmd.upd_start = 1'b1;
                            phase_next    = PH_OPENING;
                        end
                        state_next = S_EMIT;
                    end

                    PH_OPENING:
                    begin
                        code_next       = bes_pkg::CODE_OPENING;
                        cmd.div_start   = 1'b1;
                        emit_after_next = 1'b1;
                        state_next      = S_DIV;
                        if (sts.e_ge_opening)
                        begin
                            // Ramp complete: schedule the next blink after the interval
                            lvl_next       = bes_pkg::LVL_ONE;
                            cmd.div_mode   = bes_pkg::DIV_MOD_NEXT;
                            base_next      = bes_pkg::BASE_INTERVAL;
                            upd_after_next = 1'b1;
                            phase_next     = PH_INTERVAL;
                        end
                        else
                        begin
                            lvl_next       = bes_pkg::LVL_QUOT;
                            cmd.div_mode   = bes_pkg::DIV_FRAC_OPEN;
                            upd_after_next = 1'b0;
                        end
                    end

                    default:
                    begin
                        // First tick, and unused phase codes: schedule the first blink
                        cmd.div_start   = 1'b1;
                        cmd.div_mode    = bes_pkg::DIV_MOD_FIRST;
                        base_next       = bes_pkg::BASE_ZERO;
                        upd_after_next  = 1'b1;
                        emit_after_next = 1'b0;
                        phase_next      = PH_INTERVAL;
                        state_next      = S_DIV;
                    end
                endcase
            end

            S_DIV:
            begin
                if (!sts.div_busy)
                begin
                    cmd.upd_next = upd_after_reg;
                    state_next   = emit_after_reg ? S_EMIT : S_IDLE;
                end
            end

            S_EMIT:
            begin
                if (!sts.out_full)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
        endcase
    end

    // State and registered controls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_FIRST;
            lvl_reg        <= bes_pkg::LVL_ZERO;
            code_reg       <= bes_pkg::CODE_CLOSING;
            base_reg       <= bes_pkg::BASE_ZERO;
            upd_after_reg  <= 1'b0;
            emit_after_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            lvl_reg        <= lvl_next;
            code_reg       <= code_next;
            base_reg       <= base_next;
            upd_after_reg  <= upd_after_next;
            emit_after_reg <= emit_after_next;
        end
    end

    // A result is never written over one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !sts.out_full)
        else $error("result loaded into a full output register");

    // The divider is started only when it is free
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !sts.div_busy)
        else $error("divider started while busy");

    // A started division is seen as busy on the next cycle
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> sts.div_busy)
        else $error("divider did not start");

endmodule

[design/blink_envelope_sequencer.sv]
// Channel  Direction  Handshake            Payload
// s_       in         s_tvalid / s_tready  s_tdata: now_ms, random_word
// m_       out        m_tvalid / m_tready  m_tdata: openness; m_tuser: phase_code
// cfg_     in         cfg_we               cfg_addr, cfg_wdata (write only)
//
// A tick runs to its end before s_tready rises again. A waiting tick is only evaluated;
// a level without division is evaluated and loaded; a ramp level takes 15 serial divider
// steps, the first tick 16 modulo steps, the end of opening 16 modulo steps and the load.
// Reset is asynchronous and active low; it restores the default durations and the first
// phase. A stalled master side holds a result beat in the output register; the next tick
// is still accepted and waits only if it has a result of its own to place.
module blink_envelope_sequencer (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_we,
    input  logic [bes_pkg::CFG_IDX_W-1:0]            cfg_addr,
    input  logic [bes_pkg::CFG_DATA_W-1:0]           cfg_wdata,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // [31:0] now_ms, [47:32] random_word
    input  logic [bes_pkg::NOW_W+bes_pkg::RND_W-1:0] s_tdata,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // [15:0] openness
    output logic [bes_pkg::LEVEL_W-1:0]              m_tdata,
    // [1:0] phase_code
    output logic [bes_pkg::CODE_W-1:0]               m_tuser
);

    bes_pkg::cmd_t cmd;
    bes_pkg::sts_t sts;

    bes_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bes_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
